### sv/grq_pkg.sv
// Shared op codes and the result handoff type of the graph reachability query block.
package grq_pkg;

  // Width of every vertex field on the input channel.
  localparam int unsigned FIELD_W = 6;

  // Item operation codes.
  localparam logic [1:0] OP_ADD       = 2'd0;
  localparam logic [1:0] OP_CUT       = 2'd1;
  localparam logic [1:0] OP_BLOCK     = 2'd2;
  localparam logic [1:0] OP_BLOCK_ALT = 2'd3;

  // Finished query answer offered by the search engine to the output stage.
  typedef struct packed {
    logic valid;
    logic reachable;
  } grq_res_t;

endpackage

### sv/grq_adj_ram.sv
// Adjacency row memory: one write port and one read port with registered read data.
module grq_adj_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read; the read returns the old row on a same-address collision.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/grq_engine.sv
// Control and search engine: clearing pass, edge insertion and reachability sweeps.
module grq_engine #(
  parameter int unsigned NODE_COUNT = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_op,
  input  logic [grq_pkg::FIELD_W-1:0]    in_src_node,
  input  logic [grq_pkg::FIELD_W-1:0]    in_dst_node,
  input  logic [grq_pkg::FIELD_W-1:0]    in_cut_end_a,
  input  logic [grq_pkg::FIELD_W-1:0]    in_cut_end_b,
  input  logic [grq_pkg::FIELD_W-1:0]    in_blocked_node,
  output grq_pkg::grq_res_t              res,
  input  logic                           res_ready
);

  import grq_pkg::*;

  localparam int unsigned NW = $clog2(NODE_COUNT);
  localparam logic [NW-1:0] LAST_V = NW'(NODE_COUNT - 1);
  localparam logic [NODE_COUNT-1:0] ONE_ROW = NODE_COUNT'(1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_RDA,
    S_INS_WRA,
    S_INS_RDB,
    S_INS_WRB,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                state_r;
  logic [NW-1:0]         clr_cnt_r;
  logic [NW-1:0]         src_r;
  logic [NW-1:0]         dst_r;
  logic [NW-1:0]         cut_a_r;
  logic [NW-1:0]         cut_b_r;
  logic [NW-1:0]         blk_r;
  logic                  cut_a_ok_r;
  logic                  cut_b_ok_r;
  logic                  blk_ok_r;
  logic                  mode_blk_r;
  logic [NW-1:0]         ptr_r;
  logic                  chk_vld_r;
  logic [NW-1:0]         chk_v_r;
  logic [NODE_COUNT-1:0] reached_r;
  logic [NODE_COUNT-1:0] expanded_r;
  logic                  progress_r;
  logic                  answer_r;

  logic                  mem_we;
  logic [NW-1:0]         mem_waddr;
  logic [NODE_COUNT-1:0] mem_wdata;
  logic [NW-1:0]         mem_raddr;
  logic [NODE_COUNT-1:0] mem_rdata;

  logic                  src_in_range;
  logic                  dst_in_range;
  logic                  pending;
  logic                  last_chk;
  logic [NODE_COUNT-1:0] row_cut;
  logic [NODE_COUNT-1:0] row_use;

  grq_adj_ram #(
    .DEPTH (NODE_COUNT),
    .WIDTH (NODE_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Range checks on the incoming vertex fields.
  assign src_in_range = 32'(in_src_node) < 32'(NODE_COUNT);
  assign dst_in_range = 32'(in_dst_node) < 32'(NODE_COUNT);

  // Memory port control for each state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_r;
    mem_wdata = '0;
    mem_raddr = ptr_r;
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_INS_RDA: begin
        mem_raddr = src_r;
      end
      S_INS_WRA: begin
        mem_we    = 1'b1;
        mem_waddr = src_r;
        mem_wdata = mem_rdata | (ONE_ROW << dst_r);
      end
      S_INS_RDB: begin
        mem_raddr = dst_r;
      end
      S_INS_WRB: begin
        mem_we    = 1'b1;
        mem_waddr = dst_r;
        mem_wdata = mem_rdata | (ONE_ROW << src_r);
      end
      S_IDLE, S_SCAN, S_DONE: begin
        mem_raddr = ptr_r;
      end
      default: begin
        mem_raddr = ptr_r;
      end
    endcase
  end

  // The vertex whose row returns now is expanded if reached and not yet expanded.
  assign pending  = chk_vld_r && reached_r[chk_v_r] && !expanded_r[chk_v_r];
  assign last_chk = chk_vld_r && (chk_v_r == LAST_V);

  // Apply the per-query cut or blocked vertex to the returned row.
  always_comb begin
    row_cut = mem_rdata;
    if (!mode_blk_r) begin
      if ((chk_v_r == cut_a_r) && cut_a_ok_r && cut_b_ok_r) begin
        row_cut = row_cut & ~(ONE_ROW << cut_b_r);
      end
      if ((chk_v_r == cut_b_r) && cut_a_ok_r && cut_b_ok_r) begin
        row_cut = row_cut & ~(ONE_ROW << cut_a_r);
      end
    end
    row_use = (mode_blk_r && blk_ok_r && (chk_v_r == blk_r)) ? '0 : row_cut;
  end

  // Sequencer: state, captured item fields and search sets.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_cnt_r  <= '0;
      ptr_r      <= '0;
      chk_vld_r  <= 1'b0;
      progress_r <= 1'b0;
      answer_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == LAST_V) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            src_r      <= NW'(in_src_node);
            dst_r      <= NW'(in_dst_node);
            cut_a_r    <= NW'(in_cut_end_a);
            cut_b_r    <= NW'(in_cut_end_b);
            blk_r      <= NW'(in_blocked_node);
            cut_a_ok_r <= 32'(in_cut_end_a) < 32'(NODE_COUNT);
            cut_b_ok_r <= 32'(in_cut_end_b) < 32'(NODE_COUNT);
            blk_ok_r   <= 32'(in_blocked_node) < 32'(NODE_COUNT);
            mode_blk_r <= (in_op == OP_BLOCK) || (in_op == OP_BLOCK_ALT);
            reached_r  <= ONE_ROW << NW'(in_src_node);
            expanded_r <= '0;
            ptr_r      <= '0;
            chk_vld_r  <= 1'b0;
            progress_r <= 1'b0;
            if (in_op == OP_ADD) begin
              // An insert naming a vertex out of range is dropped.
              if (src_in_range && dst_in_range) begin
                state_r <= S_INS_RDA;
              end
            end else if (in_src_node == in_dst_node) begin
              answer_r <= 1'b1;
              state_r  <= S_DONE;
            end else if (!(src_in_range && dst_in_range)) begin
              answer_r <= 1'b0;
              state_r  <= S_DONE;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_INS_RDA: begin
          state_r <= S_INS_WRA;
        end
        S_INS_WRA: begin
          state_r <= S_INS_RDB;
        end
        S_INS_RDB: begin
          state_r <= S_INS_WRB;
        end
        S_INS_WRB: begin
          state_r <= S_IDLE;
        end
        S_SCAN: begin
          if (reached_r[dst_r]) begin
            answer_r <= 1'b1;
            state_r  <= S_DONE;
          end else begin
            // Keep one row read in flight per cycle while checking the previous one.
            ptr_r     <= (ptr_r == LAST_V) ? '0 : ptr_r + 1'b1;
            chk_vld_r <= 1'b1;
            chk_v_r   <= ptr_r;
            if (pending) begin
              expanded_r[chk_v_r] <= 1'b1;
              reached_r           <= reached_r | row_use;
            end
            // A full sweep that expands nothing ends the search without the target.
            if (last_chk) begin
              progress_r <= 1'b0;
              if (!(progress_r || pending)) begin
                answer_r <= 1'b0;
                state_r  <= S_DONE;
              end
            end else if (pending) begin
              progress_r <= 1'b1;
            end
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign res.valid     = (state_r == S_DONE);
  assign res.reachable = answer_r;

endmodule

### sv/graph_reachability_query_core.sv
// Top level of the graph reachability query block with its output register.
//
// Usage: items arrive on the in_ channel (valid/ready). Op 0 inserts an
// undirected edge and gives no result. Op 1 asks whether in_dst_node is
// reachable from in_src_node with the edge between the two cut ends left
// out; ops 2 and 3 ask the same with the blocked vertex not passed through.
// Each query gives one out_reachable transfer on the out_ channel.
// An insert keeps in_ready low after its transfer while it does two row
// read-modify-writes through the single adjacency memory. A query whose
// start equals its target, or names a vertex out of range, is answered
// without a sweep. Otherwise the engine sweeps all NODE_COUNT rows per
// pass, one memory read per cycle, until the target is reached or a pass
// expands nothing; at most NODE_COUNT + 1 passes are made.
// After reset the memory is cleared, one row per cycle, with in_ready low.
// A finished answer waits in the output register while the receiver
// stalls; the next item is taken meanwhile, and a second answer is held in
// the engine until the register frees.
module graph_reachability_query_core #(
  parameter int unsigned NODE_COUNT = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_op,
  input  logic [grq_pkg::FIELD_W-1:0] in_src_node,
  input  logic [grq_pkg::FIELD_W-1:0] in_dst_node,
  input  logic [grq_pkg::FIELD_W-1:0] in_cut_end_a,
  input  logic [grq_pkg::FIELD_W-1:0] in_cut_end_b,
  input  logic [grq_pkg::FIELD_W-1:0] in_blocked_node,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_reachable
);

  import grq_pkg::*;

  grq_res_t res;
  logic     res_ready;
  logic     out_valid_r;
  logic     out_reachable_r;

  grq_engine #(
    .NODE_COUNT (NODE_COUNT)
  ) u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_src_node     (in_src_node),
    .in_dst_node     (in_dst_node),
    .in_cut_end_a    (in_cut_end_a),
    .in_cut_end_b    (in_cut_end_b),
    .in_blocked_node (in_blocked_node),
    .res             (res),
    .res_ready       (res_ready)
  );

  // The engine hands over an answer when the output register is empty or emptying.
  assign res_ready = !out_valid_r || out_ready;

  // Output register for the result transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_reachable_r <= res.reachable;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_reachable = out_reachable_r;

  // The engine never takes an item while it still holds an undelivered answer.
  a_no_accept_with_answer: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> !in_ready)
    else $error("input accepted while an answer is pending");

  // A handed-over answer appears in the output register on the next cycle.
  a_handoff_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res_ready) |=> (out_valid_r && (out_reachable_r == $past(res.reachable))))
    else $error("answer lost between engine and output register");

  // A query transfer always leaves the engine busy in the cycle after it.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_op != OP_ADD)) |=> !in_ready)
    else $error("engine ready directly after a query transfer");

endmodule
